// ===== design/hbpe_pkg.sv =====
`default_nettype none

package hbpe_pkg;

  localparam int unsigned NUM_BINS    = 256;
  localparam int unsigned COUNT_WIDTH = 32;

  localparam int unsigned BIN_AW     = $clog2(NUM_BINS);
  localparam int unsigned BIN_CW     = $clog2(NUM_BINS + 1);
  localparam int unsigned NEED_W     = COUNT_WIDTH + 7;
  localparam int unsigned EDGE_W     = BIN_CW + 26;
  localparam int unsigned MUL_AW     = 17;
  localparam int unsigned MUL_BW     = 25;
  localparam int unsigned PROD_W     = MUL_AW + MUL_BW;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_PCT    = 2'd1,
    OP_MASS   = 2'd2,
    OP_CLEAR  = 2'd3
  } hbpe_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_PCT   = 2'd2
  } hbpe_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_MIN   = 3'd0,
    REG_RANGE_MAX   = 3'd1,
    REG_BIN_WIDTH   = 3'd2,
    REG_INV_WIDTH   = 3'd3,
    REG_BINS_IN_USE = 3'd4
  } hbpe_reg_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] sample;
    logic [6:0]         percent;
  } hbpe_in_t;

  typedef struct packed {
    logic signed [15:0] value_out;
    logic [31:0]        mass_out;
    logic [1:0]         status;
  } hbpe_out_t;

  // datapath strobes, at most one set per cycle
  typedef struct packed {
    logic load_in;
    logic ins_mul;
    logic ins_chk;
    logic ins_wr;
    logic clear;
    logic walk_init;
    logic walk_acc;
    logic walk_end;
    logic pct_val;
    logic load_out;
  } hbpe_cmd_t;

  typedef struct packed {
    hbpe_op_e op;
    logic     ins_ok;
    logic     special;
    logic     walk_more;
  } hbpe_sts_t;

endpackage

`default_nettype wire

// ===== design/histogram_bin_percentile_engine.sv =====
// Histogram engine over signed 16-bit samples with 256 saturating 32-bit bins, a single-port
// bin memory and a controller that steps one command at a time. An insert runs a
// multiply for the bin index, then a read-modify-write of that bin; the next word is
// taken once the result is loaded into the output register. Clear empties the store
// at once through per-bin valid bits. Percentile and mass-below queries walk the bins
// from the bottom (memory read, then accumulate, for each bin), at most as far as the
// last bin in use; trivial cases skip the walk. A finished result waits in the output
// register while the block is already free to take the next word.
// Configuration words are taken at any time but may only change while idle.

`default_nettype none

module histogram_bin_percentile_engine (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [hbpe_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [hbpe_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  hbpe_pkg::hbpe_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output hbpe_pkg::hbpe_out_t             out_data_o
);
  import hbpe_pkg::*;

  hbpe_cmd_t cmd;
  hbpe_sts_t sts;

  assign cfg_ready_o = 1'b1;

  hbpe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hbpe_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== design/hbpe_ctrl.sv =====
`default_nettype none

module hbpe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  hbpe_pkg::hbpe_sts_t sts_i,
  output hbpe_pkg::hbpe_cmd_t cmd_o
);
  import hbpe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_CHK,
    S_INS_RD,
    S_INS_WR,
    S_WALK_RD,
    S_WALK_ACC,
    S_WALK_END,
    S_PCT_VAL,
    S_FIN
  } state_e;

  state_e    state_q, state_d;
  logic      out_valid_q, out_valid_d;
  hbpe_cmd_t cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load_in = 1'b1;
          state_d     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.op)
          OP_INSERT: begin
            cmd.ins_mul = 1'b1;
            state_d     = S_INS_CHK;
          end
          OP_CLEAR: begin
            cmd.clear = 1'b1;
            state_d   = S_FIN;
          end
          default: begin
            cmd.walk_init = 1'b1;
            state_d       = sts_i.special ? S_FIN : S_WALK_RD;
          end
        endcase
      end
      S_INS_CHK: begin
        cmd.ins_chk = 1'b1;
        state_d     = sts_i.ins_ok ? S_INS_RD : S_FIN;
      end
      S_INS_RD: begin
        state_d = S_INS_WR;
      end
      S_INS_WR: begin
        cmd.ins_wr = 1'b1;
        state_d    = S_FIN;
      end
      S_WALK_RD: begin
        state_d = sts_i.walk_more ? S_WALK_ACC : S_WALK_END;
      end
      S_WALK_ACC: begin
        cmd.walk_acc = 1'b1;
        state_d      = S_WALK_RD;
      end
      S_WALK_END: begin
        cmd.walk_end = 1'b1;
        state_d      = (sts_i.op == OP_PCT) ? S_PCT_VAL : S_FIN;
      end
      S_PCT_VAL: begin
        cmd.pct_val = 1'b1;
        state_d     = S_FIN;
      end
      S_FIN: begin
        // hold the result until the output register frees up
        if (!out_valid_q || out_ready_i) begin
          cmd.load_out = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  ap_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DISPATCH))
    else $error("accepted word did not move to dispatch");

  ap_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while full");

  ap_valid_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("output valid raised outside finish state");

endmodule

`default_nettype wire

// ===== design/hbpe_dp.sv =====
`default_nettype none

module hbpe_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [hbpe_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [hbpe_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  hbpe_pkg::hbpe_in_t                  in_data_i,
  input  hbpe_pkg::hbpe_cmd_t                 cmd_i,
  output hbpe_pkg::hbpe_sts_t                 sts_o,
  output hbpe_pkg::hbpe_out_t                 out_data_o
);
  import hbpe_pkg::*;

  function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                     input logic [COUNT_WIDTH-1:0] b);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
  endfunction

  function automatic logic [31:0] sat32(input logic [COUNT_WIDTH-1:0] v);
    logic [COUNT_WIDTH+31:0] w;
    w = {32'b0, v};
    if (w > {{COUNT_WIDTH{1'b0}}, 32'hFFFF_FFFF}) begin
      return 32'hFFFF_FFFF;
    end
    return w[31:0];
  endfunction

  // configuration
  logic signed [15:0] rmin_q, rmax_q;
  logic [23:0]        bw_q, ibw_q;
  logic [8:0]         biu_q;
  logic [BIN_CW-1:0]  nb;

  // per-word working state
  hbpe_in_t                 in_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [COUNT_WIDTH-1:0]   total_q, acc_q;
  logic [NEED_W-1:0]        need_q;
  logic [BIN_CW-1:0]        i_q;
  logic signed [EDGE_W-1:0] ledge_q;
  logic signed [15:0]       value_q;
  logic [31:0]              mass_q;
  hbpe_status_e             status_q;
  hbpe_out_t                out_q;

  // bin store
  logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
  logic [NUM_BINS-1:0]    vld_q;
  logic [COUNT_WIDTH-1:0] rdata_q;
  logic                   rvld_q;
  logic [COUNT_WIDTH-1:0] cnt;

  logic signed [16:0]        diff;
  logic signed [MUL_AW-1:0]  mul_a;
  logic signed [MUL_BW-1:0]  mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [PROD_W-1:0]  idx_sh;
  logic [BIN_CW-1:0]         ins_idx;
  logic                      ins_ok;
  logic [BIN_CW-1:0]         pidx;
  logic [NEED_W-1:0]         acc100;
  logic [NEED_W-1:0]         need_d;
  logic signed [EDGE_W-1:0]  lim, base, bw_ext;
  logic                      pct_special, mass_special, pct_more, mass_more;
  logic                      smp_le_min, smp_ge_max;
  logic signed [PROD_W-1:0]  pct_v;
  logic signed [15:0]        pct_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rmin_q <= 16'sd0;
      rmax_q <= 16'sd32767;
      bw_q   <= 24'd256;
      ibw_q  <= 24'd65536;
      biu_q  <= 9'd256;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_RANGE_MIN:   rmin_q <= cfg_data_i[15:0];
        REG_RANGE_MAX:   rmax_q <= cfg_data_i[15:0];
        REG_BIN_WIDTH:   bw_q   <= cfg_data_i;
        REG_INV_WIDTH:   ibw_q  <= cfg_data_i;
        REG_BINS_IN_USE: biu_q  <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (biu_q == 9'd0) begin
      nb = BIN_CW'(1);
    end else if (32'(biu_q) > 32'(NUM_BINS)) begin
      nb = BIN_CW'(NUM_BINS);
    end else begin
      nb = BIN_CW'(biu_q);
    end
  end

  // shared multiplier: bin index on insert, bin edge offset on percentile
  assign diff = {in_q.sample[15], in_q.sample} - {rmin_q[15], rmin_q};

  always_comb begin
    if (cmd_i.ins_mul) begin
      mul_a = diff;
      mul_b = $signed({1'b0, ibw_q});
    end else begin
      mul_a = $signed({{(MUL_AW - BIN_CW){1'b0}}, pidx});
      mul_b = $signed({1'b0, bw_q});
    end
  end

  assign mul_p = mul_a * mul_b;

  assign idx_sh = prod_q >>> 16;

  always_comb begin
    if (in_q.sample == rmax_q) begin
      ins_ok  = 1'b1;
      ins_idx = nb - BIN_CW'(1);
    end else if (prod_q[PROD_W-1]) begin
      ins_ok  = 1'b0;
      ins_idx = '0;
    end else begin
      ins_ok  = (idx_sh < $signed({{(PROD_W - BIN_CW){1'b0}}, nb}));
      ins_idx = idx_sh[BIN_CW-1:0];
    end
  end

  assign cnt    = rvld_q ? rdata_q : '0;
  assign acc100 = NEED_W'({acc_q, 6'b0}) + NEED_W'({acc_q, 5'b0}) + NEED_W'({acc_q, 2'b0});
  assign need_d = NEED_W'(total_q) * NEED_W'(in_q.percent);

  assign lim    = {{(EDGE_W - 24){in_q.sample[15]}}, in_q.sample, 8'h00};
  assign base   = {{(EDGE_W - 24){rmin_q[15]}}, rmin_q, 8'h00};
  assign bw_ext = $signed({{(EDGE_W - 24){1'b0}}, bw_q});

  assign smp_le_min   = ($signed(in_q.sample) <= rmin_q);
  assign smp_ge_max   = ($signed(in_q.sample) >= rmax_q);
  assign pct_special  = (in_q.percent == 7'd0) || (in_q.percent >= 7'd100);
  assign mass_special = smp_le_min || smp_ge_max;
  assign pct_more     = (acc100 < need_q) && (i_q < nb);
  assign mass_more    = (i_q < nb) && (ledge_q <= lim);

  // exact hit lands on the bin after the walk, otherwise step back one
  always_comb begin
    if (acc100 == need_q) begin
      pidx = i_q;
    end else if (i_q == '0) begin
      pidx = '0;
    end else begin
      pidx = i_q - BIN_CW'(1);
    end
  end

  assign pct_v = ((prod_q + PROD_W'(128)) >>> 8) + {{(PROD_W - 16){rmin_q[15]}}, rmin_q};

  always_comb begin
    if (!pct_v[PROD_W-1] && (pct_v[PROD_W-2:15] != '0)) begin
      pct_value = 16'sh7FFF;
    end else if (pct_v[PROD_W-1] && (pct_v[PROD_W-2:15] != '1)) begin
      pct_value = 16'sh8000;
    end else begin
      pct_value = pct_v[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_wr) begin
      mem[i_q[BIN_AW-1:0]] <= sat_add(cnt, COUNT_WIDTH'(1));
    end
    rdata_q <= mem[i_q[BIN_AW-1:0]];
    rvld_q  <= vld_q[i_q[BIN_AW-1:0]];
  end

  // a bin without its valid bit reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      total_q <= '0;
    end else if (cmd_i.clear) begin
      vld_q   <= '0;
      total_q <= '0;
    end else if (cmd_i.ins_wr) begin
      vld_q[i_q[BIN_AW-1:0]] <= 1'b1;
      total_q                <= sat_add(total_q, COUNT_WIDTH'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q     <= in_data_i;
      value_q  <= '0;
      mass_q   <= '0;
      status_q <= ST_OK;
    end
    if (cmd_i.ins_mul) begin
      prod_q <= mul_p;
    end
    if (cmd_i.ins_chk) begin
      i_q <= ins_idx;
      if (!ins_ok) begin
        status_q <= ST_RANGE;
      end
    end
    if (cmd_i.walk_init) begin
      acc_q   <= '0;
      i_q     <= '0;
      need_q  <= need_d;
      ledge_q <= base;
      if (in_q.cmd == OP_PCT) begin
        if (in_q.percent > 7'd100) begin
          status_q <= ST_PCT;
        end else if (in_q.percent == 7'd0) begin
          value_q <= rmin_q;
        end else if (in_q.percent == 7'd100) begin
          value_q <= rmax_q;
        end
      end else if (!smp_le_min && smp_ge_max) begin
        mass_q <= sat32(total_q);
      end
    end
    if (cmd_i.walk_acc) begin
      acc_q   <= sat_add(acc_q, cnt);
      i_q     <= i_q + BIN_CW'(1);
      ledge_q <= ledge_q + bw_ext;
    end
    if (cmd_i.walk_end) begin
      prod_q <= mul_p;
      if (in_q.cmd == OP_MASS) begin
        mass_q <= sat32(acc_q);
      end
    end
    if (cmd_i.pct_val) begin
      value_q <= pct_value;
    end
    if (cmd_i.load_out) begin
      out_q.value_out <= value_q;
      out_q.mass_out  <= mass_q;
      out_q.status    <= status_q;
    end
  end

  assign sts_o.op        = hbpe_op_e'(in_q.cmd);
  assign sts_o.ins_ok    = ins_ok;
  assign sts_o.special   = (in_q.cmd == OP_PCT) ? pct_special : mass_special;
  assign sts_o.walk_more = (in_q.cmd == OP_PCT) ? pct_more : mass_more;
  assign out_data_o      = out_q;

  ap_ins_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins_wr |-> (i_q < nb))
    else $error("insert writes a bin outside the bins in use");

  ap_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_acc |-> (i_q < nb))
    else $error("walk reads past the last bin in use");

  ap_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> ((total_q == '0) && (vld_q == '0)))
    else $error("clear left counts behind");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hbpe_pkg::*;

  localparam longint COUNT_MAX = (longint'(1) << COUNT_WIDTH) - 1;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  hbpe_in_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  hbpe_out_t             out_data_o;

  // histogram as the block should hold it
  longint             bin_tally [NUM_BINS] = '{default: 0};
  longint             total_tally = 0;
  logic signed [15:0] cfg_lo = 16'sd0;
  logic signed [15:0] cfg_hi = 16'sd32767;
  logic [23:0]        cfg_bw = 24'd256;
  logic [23:0]        cfg_inv = 24'd65536;
  logic [8:0]         cfg_bins = 9'd256;

  hbpe_out_t answers_due [$];
  int        errors = 0;
  int        send_idle = 0;
  int        recv_stall = 0;
  int        hold_left = 0;

  histogram_bin_percentile_engine uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint clip_count(input longint v);
    return (v > COUNT_MAX) ? COUNT_MAX : v;
  endfunction

  // Apply one command word to the histogram and return the answer it should give.
  function automatic hbpe_out_t histogram_step(input hbpe_in_t w);
    hbpe_out_t r;
    longint    smp, lo, hi, nb, idx, prod, need, acc, q, val, lim, base, mass, i;
    r    = '0;
    smp  = longint'($signed(w.sample));
    lo   = longint'(cfg_lo);
    hi   = longint'(cfg_hi);
    nb   = (cfg_bins == 0) ? 1 : (cfg_bins > NUM_BINS) ? NUM_BINS : longint'(cfg_bins);
    mass = 0;
    case (w.cmd)
      OP_INSERT: begin
        if (smp == hi) begin
          idx = nb - 1;
        end else begin
          prod = (smp - lo) * longint'(cfg_inv);
          idx  = (prod < 0) ? -1 : (prod >>> 16);
        end
        if (idx < 0 || idx >= nb) begin
          r.status = ST_RANGE;
        end else begin
          bin_tally[idx] = clip_count(bin_tally[idx] + 1);
          total_tally    = clip_count(total_tally + 1);
        end
      end
      OP_PCT: begin
        if (w.percent > 100) begin
          r.status = ST_PCT;
        end else if (w.percent == 0) begin
          r.value_out = cfg_lo;
        end else if (w.percent == 100) begin
          r.value_out = cfg_hi;
        end else begin
          need = total_tally * longint'(w.percent);
          acc  = 0;
          i    = 0;
          while (acc * 100 < need && i < nb) begin
            acc = clip_count(acc + bin_tally[i]);
            i++;
          end
          idx = (acc * 100 == need) ? i : i - 1;
          if (idx < 0) idx = 0;
          q   = (idx * longint'(cfg_bw) + 128) >>> 8;
          val = lo + q;
          if (val > 32767) val = 32767;
          if (val < -32768) val = -32768;
          r.value_out = val[15:0];
        end
      end
      OP_MASS: begin
        if (smp <= lo) begin
          mass = 0;
        end else if (smp >= hi) begin
          mass = total_tally;
        end else begin
          lim  = smp * 256;
          base = lo * 256;
          i    = 0;
          // left edges in Q8, compared exactly
          while (i < nb && base + i * longint'(cfg_bw) <= lim) begin
            mass = clip_count(mass + bin_tally[i]);
            i++;
          end
        end
        r.mass_out = mass[31:0];
      end
      default: begin
        foreach (bin_tally[k]) bin_tally[k] = 0;
        total_tally = 0;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_answer(input hbpe_out_t got);
    hbpe_out_t want;
    if (answers_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result word %h", got));
      return;
    end
    want = answers_due.pop_front();
    if (got.value_out !== want.value_out)
      report_mismatch($sformatf("value_out got %0d want %0d", got.value_out, want.value_out));
    if (got.mass_out !== want.mass_out)
      report_mismatch($sformatf("mass_out got %0d want %0d", got.mass_out, want.mass_out));
    if (got.status !== want.status)
      report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
  endtask

  // Result side: check each accepted word, then pick ready for the next edge.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) check_answer(out_data_o);
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_RANGE_MIN:   cfg_lo = data[15:0];
      REG_RANGE_MAX:   cfg_hi = data[15:0];
      REG_BIN_WIDTH:   cfg_bw = data;
      REG_INV_WIDTH:   cfg_inv = data;
      REG_BINS_IN_USE: cfg_bins = data[8:0];
      default: ;
    endcase
  endtask

  // Upper data bits beyond each register's width are noise.
  task automatic apply_config(input longint lo, input longint hi, input logic [23:0] bw,
                              input logic [23:0] ibw, input logic [8:0] nb, input bit stray);
    write_reg(REG_RANGE_MIN, {8'($urandom), 16'(lo)});
    write_reg(REG_RANGE_MAX, {8'($urandom), 16'(hi)});
    write_reg(REG_BIN_WIDTH, bw);
    write_reg(REG_INV_WIDTH, ibw);
    write_reg(REG_BINS_IN_USE, {15'($urandom), nb});
    if (stray) write_reg(CFG_IDX_W'($urandom_range(7, 5)), 24'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_word(input hbpe_in_t w);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    answers_due.push_back(histogram_step(w));
  endtask

  // Drop valid and hold off until every expected word has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (answers_due.size() != 0);
  endtask

  function automatic hbpe_in_t make_word(input hbpe_op_e op, input int smp, input int pct);
    hbpe_in_t w;
    w.cmd     = op;
    w.sample  = 16'(smp);
    w.percent = 7'(pct);
    return w;
  endfunction

  function automatic hbpe_in_t random_word();
    hbpe_in_t    w;
    int unsigned roll;
    longint      lo, hi;
    w.cmd     = 2'($urandom);
    w.sample  = 16'($urandom);
    w.percent = 7'($urandom);
    lo        = longint'(cfg_lo);
    hi        = longint'(cfg_hi);
    roll      = $urandom_range(99);
    if (roll < 55) w.cmd = OP_INSERT;
    else if (roll < 75) w.cmd = OP_PCT;
    else if (roll < 95) w.cmd = OP_MASS;
    else if (roll < 97) w.cmd = OP_CLEAR;
    // aim most samples into the configured range
    roll = $urandom_range(99);
    if (hi > lo && roll < 80) w.sample = 16'(lo + longint'($urandom_range(32'(hi - lo), 0)));
    else if (roll < 88) w.sample = roll[0] ? cfg_hi : cfg_lo;
    roll = $urandom_range(99);
    if (roll < 80) w.percent = 7'($urandom_range(99, 1));
    else if (roll < 88) w.percent = roll[0] ? 7'd100 : 7'd0;
    return w;
  endfunction

  // Pick a consistent range, mostly with few bins so the walks stay short.
  task automatic random_setup();
    int unsigned nb, step, span;
    longint      lo, hi;
    logic [23:0] bw;
    bit          flip;
    nb   = ($urandom_range(7) == 0) ? $urandom_range(256, 25) : $urandom_range(24, 1);
    step = ($urandom_range(3) == 0) ? $urandom_range(2000, 1) : $urandom_range(40, 1);
    if (step * nb > 60000) step = 60000 / nb;
    span = step * nb;
    lo   = longint'($urandom_range(65535 - span, 0)) - 32768;
    hi   = lo + longint'(span);
    // leave the top bin partly outside the range now and then
    if ($urandom_range(3) == 0) hi = hi - longint'($urandom_range(step - 1, 0));
    flip = ($urandom_range(9) == 0);
    bw   = 24'(step * 256 + (($urandom_range(3) == 0) ? $urandom_range(255, 0) : 0));
    apply_config(flip ? hi : lo, flip ? lo : hi, bw, 24'((longint'(1) << 24) / bw),
                 9'(nb), 1'b0);
  endtask

  task automatic test_directed();
    send_idle  = 0;
    recv_stall = 0;
    // reset settings: unit bins from zero
    send_word(make_word(OP_INSERT, 0, 0));
    send_word(make_word(OP_INSERT, 32767, 127));
    send_word(make_word(OP_INSERT, -32768, 0));
    send_word(make_word(OP_INSERT, 300, 0));
    send_word(make_word(OP_PCT, 0, 50));
    send_word(make_word(OP_PCT, 0, 0));
    send_word(make_word(OP_PCT, 0, 100));
    send_word(make_word(OP_PCT, 0, 101));
    send_word(make_word(OP_PCT, -1, 127));
    send_word(make_word(OP_MASS, 32767, 0));
    send_word(make_word(OP_MASS, 1, 0));
    send_word(make_word(OP_MASS, -5, 0));
    drain();
    apply_config(-100, 100, 24'd5120, 24'd3277, 9'd10, 1'b1);
    send_word(make_word(OP_INSERT, -100, 0));
    send_word(make_word(OP_INSERT, 100, 0));
    send_word(make_word(OP_INSERT, -101, 0));
    send_word(make_word(OP_INSERT, 101, 0));
    send_word(make_word(OP_INSERT, 35, 0));
    send_word(make_word(OP_PCT, 0, 1));
    send_word(make_word(OP_PCT, 0, 67));
    send_word(make_word(OP_MASS, 0, 0));
    send_word(make_word(OP_MASS, 100, 0));
    send_word(make_word(OP_CLEAR, 0, 0));
    send_word(make_word(OP_PCT, 0, 50));
    send_word(make_word(OP_MASS, 50, 0));
    drain();
  endtask

  task automatic test_config_extremes();
    send_idle  = 17;
    recv_stall = 17;
    apply_config(-32768, 32767, 24'd0, 24'hFFFFFF, 9'd0, 1'b0);
    repeat (30) send_word(random_word());
    drain();
    apply_config(-32768, 32767, 24'hFFFFFF, 24'd0, 9'd511, 1'b0);
    repeat (30) send_word(random_word());
    drain();
    // inverted range
    apply_config(100, -100, 24'd2560, 24'd6554, 9'd20, 1'b0);
    repeat (30) send_word(random_word());
    drain();
    apply_config(-5, -5, 24'd256, 24'd65536, 9'd1, 1'b0);
    repeat (30) send_word(random_word());
    drain();
    apply_config(-32768, 32767, 24'd65536, 24'd256, 9'd256, 1'b0);
    repeat (30) send_word(random_word());
    drain();
    apply_config(-1000, 1000, 24'd1920, 24'd8738, 9'd300, 1'b0);
    repeat (30) send_word(random_word());
    drain();
    apply_config(32767, -32768, 24'd512, 24'd32768, 9'd2, 1'b0);
    repeat (30) send_word(random_word());
    drain();
  endtask

  task automatic test_idle_mix(input int sidle, input int rstall);
    send_idle  = sidle;
    recv_stall = rstall;
    repeat (4) begin
      random_setup();
      repeat (75) send_word(random_word());
      drain();
    end
  endtask

  // Hold the result side for a long stretch while words keep coming.
  task automatic test_backpressure();
    send_idle  = 0;
    recv_stall = 0;
    random_setup();
    hold_left = 300;
    repeat (16) send_word(random_word());
    drain();
  endtask

  initial begin
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_ready_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_idle_mix(0, 0);
    test_idle_mix(76, 0);
    test_idle_mix(0, 76);
    test_idle_mix(17, 17);
    test_backpressure();
    // let any stray word surface
    repeat (600) @(posedge clk_i);
    if (errors == 0 && answers_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== histogram_bin_percentile_engine.f =====
design/hbpe_pkg.sv
design/hbpe_ctrl.sv
design/hbpe_dp.sv
design/histogram_bin_percentile_engine.sv
tb/tb.sv
